@@ hw/rtl/bmhq_pkg.sv @@
// shared types and constants for the binary max-heap queue
`timescale 1ns / 1ps

package bmhq_pkg;

   // number of values the queue can hold
   localparam int CAPACITY = 128;
   localparam int DATA_W   = 32;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int ENTRY_W  = 8;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [COUNT_W-1:0]       count_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic     ins;
      logic     rem;
      data_type value;
   } cmd_type;

   // one result item
   typedef struct packed {
      status_type          status;
      data_type            removed;
      data_type            top;
      logic [ENTRY_W-1:0]  count;
   } rsp_type;

endpackage

@@ hw/rtl/bmhq_cell.sv @@
// one cell of the sorted register chain, largest value at cell zero
`timescale 1ns / 1ps

module bmhq_cell (
   input  logic               clock,
   input  bmhq_pkg::cmd_type  cmd,
   input  logic               prev_occ,
   input  bmhq_pkg::data_type prev_val,
   input  logic               own_occ,
   input  bmhq_pkg::data_type next_val,
   output bmhq_pkg::data_type val
);
   import bmhq_pkg::*;

   data_type val_ff;
   data_type val_in;

   // insert shifts smaller entries one cell down, remove shifts all up by one
   always_comb begin
      val_in = val_ff;
      if (cmd.ins) begin
         if (own_occ && (val_ff >= cmd.value)) begin
            val_in = val_ff;
         end else if (!prev_occ || (prev_val >= cmd.value)) begin
            val_in = cmd.value;
         end else begin
            val_in = prev_val;
         end
      end else if (cmd.rem) begin
         val_in = next_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val = val_ff;

endmodule

@@ hw/rtl/bmhq_ctrl.sv @@
// entry count, status decode and result assembly for the heap queue
`timescale 1ns / 1ps

module bmhq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  bmhq_pkg::op_type    op,
   input  bmhq_pkg::data_type  value,
   input  bmhq_pkg::data_type  head,
   input  bmhq_pkg::data_type  second,
   output bmhq_pkg::cmd_type   cmd,
   output bmhq_pkg::rsp_type   rsp,
   output bmhq_pkg::count_type count
);
   import bmhq_pkg::*;

   count_type count_ff;
   count_type count_in;
   logic      is_full;
   logic      is_empty;

   assign is_full  = (count_ff == COUNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);

   // commands to the chain
   always_comb begin
      cmd.ins   = accept && (op == OP_INSERT) && !is_full;
      cmd.rem   = accept && (op == OP_REMOVE) && !is_empty;
      cmd.value = value;
   end

   // next count
   always_comb begin
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (cmd.rem) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // result fields as they stand after this request
   always_comb begin
      rsp.status  = STATUS_OK;
      rsp.removed = '0;
      rsp.top     = head;
      rsp.count   = ENTRY_W'(count_in);
      case (op)
         OP_INSERT: begin
            if (is_full) begin
               rsp.status = STATUS_FULL;
            end else if (is_empty || (value > head)) begin
               rsp.top = value;
            end
         end
         OP_REMOVE: begin
            if (is_empty) begin
               rsp.status = STATUS_EMPTY;
               rsp.top    = '0;
            end else begin
               rsp.removed = head;
               rsp.top     = (count_ff > COUNT_W'(1)) ? second : '0;
            end
         end
         default: begin
            rsp.status = STATUS_OK;
         end
      endcase
   end

   assign count = count_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.ins && cmd.rem))
      else $error("insert and remove in the same cycle");

   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && (op == OP_INSERT) && is_full) |=> $stable(count_ff))
      else $error("refused insert changed the count");

   a_remove_dec: assert property (@(posedge clock) disable iff (reset)
      (accept && (op == OP_REMOVE) && !is_empty)
         |=> (count_ff == $past(count_ff) - COUNT_W'(1)))
      else $error("remove did not drop the count by one");

endmodule

@@ hw/rtl/binary_max_heap_queue.sv @@
// top level of the binary max-heap priority queue
`timescale 1ns / 1ps

// Priority queue of signed 32-bit values, up to CAPACITY entries (package
// constant, 128 here). The contents live in a chain of cells kept in
// descending order, so cell zero always holds the maximum; every request
// updates all cells at once, an insert shifting the smaller entries one cell
// down and a remove shifting every entry one cell up. The result of a
// request therefore appears in the output register on the next cycle, and a
// new request is taken in every cycle in which that register is empty or
// being drained, so the rate is one request per cycle set by the output
// handshake. Each request yields exactly one result: the status, the removed
// maximum (zero unless a remove succeeded), the maximum after the request
// (zero when empty) and the low 8 bits of the entry count. A refused insert
// on a full queue or remove on an empty queue leaves the contents as they
// were.
module binary_max_heap_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   input  logic [0:0]  req_tuser,   // op[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // removed_value[31:0], top_value[63:32],
                                    // entry_count[71:64]
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import bmhq_pkg::*;

   logic      accept;
   cmd_type   cmd;
   rsp_type   rsp;
   count_type count;
   data_type  cell_val [CAPACITY];
   logic      occ      [CAPACITY];

   rsp_type   rsp_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // request handshake
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   bmhq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .op     (op_type'(req_tuser[0])),
      .value  (data_type'(req_tdata)),
      .head   (cell_val[0]),
      .second (cell_val[1]),
      .cmd    (cmd),
      .rsp    (rsp),
      .count  (count)
   );

   // chain of cells, occupancy follows from the entry count
   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      assign occ[gi] = (count > COUNT_W'(gi));

      if (gi == 0) begin : g_first
         bmhq_cell u_cell (
            .clock    (clock),
            .cmd      (cmd),
            .prev_occ (1'b0),
            .prev_val ('0),
            .own_occ  (occ[gi]),
            .next_val (cell_val[gi+1]),
            .val      (cell_val[gi])
         );
      end else if (gi == CAPACITY - 1) begin : g_last
         bmhq_cell u_cell (
            .clock    (clock),
            .cmd      (cmd),
            .prev_occ (occ[gi-1]),
            .prev_val (cell_val[gi-1]),
            .own_occ  (occ[gi]),
            .next_val ('0),
            .val      (cell_val[gi])
         );
      end else begin : g_mid
         bmhq_cell u_cell (
            .clock    (clock),
            .cmd      (cmd),
            .prev_occ (occ[gi-1]),
            .prev_val (cell_val[gi-1]),
            .own_occ  (occ[gi]),
            .next_val (cell_val[gi+1]),
            .val      (cell_val[gi])
         );
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.count, rsp_ff.top, rsp_ff.removed};
   assign rsp_tuser  = rsp_ff.status;

endmodule
